// ===== rtl/dsr_pkg.sv =====
// shared types and constants of the dfa string recognizer
// item codes, queue entry layout and table geometry; no dependencies
`default_nettype none

package dsr_pkg;

  localparam int NUM_STATES  = 16;
  localparam int STATE_W     = 4;
  localparam int SYM_W       = 8;
  localparam int CMD_W       = 2;
  localparam int IDX_W       = $clog2(NUM_STATES);
  localparam int TBL_AW      = IDX_W + SYM_W;
  localparam int TBL_DEPTH   = NUM_STATES << SYM_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 8;

  typedef enum logic [CMD_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_MARK   = 2'd1,
    OP_SYMBOL = 2'd2,
    OP_END    = 2'd3
  } op_kind_e;

  typedef struct packed {
    op_kind_e             kind;
    logic [STATE_W-1:0]   state_idx;
    logic [SYM_W-1:0]     sym;
    logic [STATE_W-1:0]   nxt;
    logic                 acc;
  } op_t;

  typedef struct packed {
    logic                 valid;
    logic [STATE_W-1:0]   nxt;
  } tbl_entry_t;

endpackage

`default_nettype wire

// ===== rtl/dsr_front.sv =====
// front end: decodes an input beat into a queue entry and drops no-op items
// depends on dsr_pkg
`default_nettype none

module dsr_front
  import dsr_pkg::*;
(
  input  logic                  s_valid_i,
  output logic                  s_ready_o,
  input  logic [IN_DATA_W-1:0]  s_data_i,
  input  logic [CMD_W-1:0]      s_user_i,
  input  logic                  clr_done_i,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output op_t                   push_op_o
);

  op_t  op;
  logic src_ok;
  logic dst_ok;
  logic keep;

  always_comb begin
    op.kind      = op_kind_e'(s_user_i);
    op.state_idx = s_data_i[3:0];
    op.sym       = s_data_i[11:4];
    op.nxt       = s_data_i[15:12];
    op.acc       = s_data_i[16];
  end

  assign src_ok = int'(op.state_idx) < NUM_STATES;
  assign dst_ok = int'(op.nxt) < NUM_STATES;

  // out-of-range writes and marks change nothing, so they never reach the queue
  always_comb begin
    unique case (op.kind)
      OP_WRITE: keep = src_ok & dst_ok;
      OP_MARK:  keep = src_ok;
      default:  keep = 1'b1;
    endcase
  end

  assign s_ready_o    = push_ready_i & clr_done_i;
  assign push_valid_o = s_valid_i & s_ready_o & keep;
  assign push_op_o    = op;

endmodule

`default_nettype wire

// ===== rtl/dsr_queue.sv =====
// short fifo of decoded items between front and back end
// depends on dsr_pkg
`default_nettype none

module dsr_queue
  import dsr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  op_t  push_op_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output op_t  pop_op_o
);

  op_t                 q_mem [QUEUE_DEPTH];
  logic [QUEUE_AW:0]   wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW:0]   rd_ptr_q, rd_ptr_d;
  logic                full;
  logic                empty;
  logic                do_push;
  logic                do_pop;

  assign empty = wr_ptr_q == rd_ptr_q;
  assign full  = (wr_ptr_q[QUEUE_AW] != rd_ptr_q[QUEUE_AW]) &&
                 (wr_ptr_q[QUEUE_AW-1:0] == rd_ptr_q[QUEUE_AW-1:0]);

  assign push_ready_o = ~full;
  assign pop_valid_o  = ~empty;
  assign pop_op_o     = q_mem[rd_ptr_q[QUEUE_AW-1:0]];

  assign do_push  = push_valid_i & ~full;
  assign do_pop   = pop_ready_i & ~empty;
  assign wr_ptr_d = wr_ptr_q + (QUEUE_AW+1)'(do_push);
  assign rd_ptr_d = rd_ptr_q + (QUEUE_AW+1)'(do_pop);

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_ptr_q[QUEUE_AW-1:0]] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dsr_back.sv =====
// back end: transition table, automaton state, accepting flags and result register
// depends on dsr_pkg; the table clears itself after reset
`default_nettype none

module dsr_back
  import dsr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [STATE_W-1:0] start_state_i,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  op_t                pop_op_i,
  output logic               clr_done_o,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic               res_accepted_o,
  output logic               res_stuck_o
);

  tbl_entry_t          tbl_mem [TBL_DEPTH];
  tbl_entry_t          rd_q;
  logic                tbl_we;
  logic [TBL_AW-1:0]   tbl_wa;
  tbl_entry_t          tbl_wd;
  logic                tbl_re;
  logic [TBL_AW-1:0]   tbl_ra;

  logic                clr_q, clr_d;
  logic [TBL_AW-1:0]   clr_cnt_q, clr_cnt_d;

  logic [STATE_W-1:0]  cur_q, cur_d;
  logic                dead_q, dead_d;
  logic                pend_q, pend_d;
  logic [NUM_STATES-1:0] acc_q, acc_d;

  logic                out_valid_q, out_valid_d;
  logic                out_acc_q, out_acc_d;
  logic                out_stuck_q, out_stuck_d;

  logic [STATE_W-1:0]  eff_cur;
  logic                eff_dead;
  logic                cur_ok;
  logic                out_free;
  logic                do_pop;

  // a lookup issued last cycle lands in rd_q and is folded into the state here
  assign eff_cur  = (pend_q && rd_q.valid) ? rd_q.nxt : cur_q;
  assign eff_dead = dead_q | (pend_q & ~rd_q.valid);
  assign cur_ok   = int'(eff_cur) < NUM_STATES;

  assign out_free    = ~out_valid_q | res_ready_i;
  assign pop_ready_o = ~clr_q & ((pop_op_i.kind != OP_END) | out_free);
  assign do_pop      = pop_valid_i & pop_ready_o;
  assign clr_done_o  = ~clr_q;

  always_comb begin
    tbl_we      = 1'b0;
    tbl_wa      = {pop_op_i.state_idx[IDX_W-1:0], pop_op_i.sym};
    tbl_wd      = '{valid: 1'b1, nxt: pop_op_i.nxt};
    tbl_re      = 1'b0;
    tbl_ra      = {eff_cur[IDX_W-1:0], pop_op_i.sym};
    clr_d       = clr_q;
    clr_cnt_d   = clr_cnt_q;
    cur_d       = eff_cur;
    dead_d      = eff_dead;
    pend_d      = 1'b0;
    acc_d       = acc_q;
    out_valid_d = out_valid_q & ~res_ready_i;
    out_acc_d   = out_acc_q;
    out_stuck_d = out_stuck_q;

    if (clr_q) begin
      tbl_we    = 1'b1;
      tbl_wa    = clr_cnt_q;
      tbl_wd    = '0;
      clr_cnt_d = clr_cnt_q + TBL_AW'(1);
      if (clr_cnt_q == TBL_AW'(TBL_DEPTH - 1)) begin
        clr_d = 1'b0;
      end
    end else if (do_pop) begin
      unique case (pop_op_i.kind)
        OP_WRITE: begin
          tbl_we = 1'b1;
        end
        OP_MARK: begin
          acc_d[pop_op_i.state_idx[IDX_W-1:0]] = pop_op_i.acc;
        end
        OP_SYMBOL: begin
          if (!eff_dead && cur_ok) begin
            tbl_re = 1'b1;
            pend_d = 1'b1;
          end else begin
            dead_d = 1'b1;
          end
        end
        OP_END: begin
          out_valid_d = 1'b1;
          out_stuck_d = eff_dead;
          out_acc_d   = ~eff_dead & cur_ok & acc_q[eff_cur[IDX_W-1:0]];
          cur_d       = start_state_i;
          dead_d      = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    if (tbl_re) begin
      rd_q <= tbl_mem[tbl_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= 1'b1;
      clr_cnt_q   <= '0;
      cur_q       <= '0;
      dead_q      <= 1'b0;
      pend_q      <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      clr_q       <= clr_d;
      clr_cnt_q   <= clr_cnt_d;
      cur_q       <= cur_d;
      dead_q      <= dead_d;
      pend_q      <= pend_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_acc_q   <= out_acc_d;
    out_stuck_q <= out_stuck_d;
  end

  assign res_valid_o    = out_valid_q;
  assign res_accepted_o = out_acc_q;
  assign res_stuck_o    = out_stuck_q;

endmodule

`default_nettype wire

// ===== rtl/dfa_string_recognizer.sv =====
// top level of the table-driven dfa string recognizer
// depends on dsr_pkg, dsr_front, dsr_queue and dsr_back
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid_i/tready_o       tdata: state_index, symbol, next_state,
//                                                 accepting; tuser: command
//   m_axis    out  m_axis_tvalid_o/tready_i       tdata: accepted, stuck
//   cfg       in   cfg_valid_i/cfg_ready_o        start_state
//
// one beat per cycle in and out; a symbol looks up the table with the state that the
// previous lookup returned, so the memory read port sets that pace when not stalled
// an end-of-string beat leaves a registered result in the cycle after it leaves the queue
// after reset the transition table is cleared one entry a cycle, all 4096 entries, with
// s_axis_tready_o low; cfg writes are taken at any time
// a stalled result holds the back end only on end-of-string beats; the 4-entry queue
// absorbs the rest
`default_nettype none

module dfa_string_recognizer
  import dsr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]   s_axis_tdata_i,  // state_index, symbol, next_state, accepting
  input  logic [CMD_W-1:0]       s_axis_tuser_i,  // command
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_DATA_W-1:0]  m_axis_tdata_o,  // accepted, stuck
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [STATE_W-1:0]     cfg_data_i
);

  logic [STATE_W-1:0] start_q;
  logic               push_valid;
  logic               push_ready;
  op_t                push_op;
  logic               pop_valid;
  logic               pop_ready;
  op_t                pop_op;
  logic               clr_done;
  logic               res_accepted;
  logic               res_stuck;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
    end else if (cfg_valid_i) begin
      start_q <= cfg_data_i;
    end
  end

  dsr_front u_front (
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .s_data_i     (s_axis_tdata_i),
    .s_user_i     (s_axis_tuser_i),
    .clr_done_i   (clr_done),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_op_o    (push_op)
  );

  dsr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_op_i    (push_op),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_op_o     (pop_op)
  );

  dsr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_state_i  (start_q),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_op_i       (pop_op),
    .clr_done_o     (clr_done),
    .res_valid_o    (m_axis_tvalid_o),
    .res_ready_i    (m_axis_tready_i),
    .res_accepted_o (res_accepted),
    .res_stuck_o    (res_stuck)
  );

  assign m_axis_tdata_o = {(OUT_DATA_W-2)'(0), res_stuck, res_accepted};

endmodule

`default_nettype wire
